/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising edge while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/cal_clk_pkg.sv */
// Types, constants and calendar tables for the calendar clock.
package cal_clk_pkg;

  // Beat kinds carried on in_tuser.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Rollover codes.
  localparam logic [1:0] ROLL_NONE  = 2'd0;
  localparam logic [1:0] ROLL_HOUR  = 2'd1;
  localparam logic [1:0] ROLL_DAY   = 2'd2;
  localparam logic [1:0] ROLL_MONTH = 2'd3;

  localparam logic [5:0] SEC_WRAP     = 6'd60;
  localparam logic [5:0] MIN_WRAP     = 6'd60;
  localparam logic [4:0] HOUR_WRAP    = 5'd24;
  localparam logic [3:0] MONTH_DEC    = 4'd12;
  localparam logic [3:0] MONTH_JAN    = 4'd1;
  localparam logic [4:0] DAY_FIRST    = 5'd1;
  localparam logic [2:0] WEEKDAY_LAST = 3'd7;
  localparam logic [8:0] DAYS_YEAR    = 9'd365;
  localparam logic [8:0] DAYS_LEAP    = 9'd366;
  localparam logic [31:0] RESET_YEAR  = 32'd2000;

  // Input beat payload, lowest field last.
  typedef struct packed {
    logic [3:0]  pad;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [15:0] load_year;
  } in_data_t;

  // Output beat payload, lowest field last.
  typedef struct packed {
    logic        pad;
    logic [31:0] total_days;
    logic [1:0]  rollover;
    logic [16:0] seconds_of_day;
    logic [5:0]  week_of_year;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } out_data_t;

  // Days in a month; zero for codes that are not a month.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:       len = 5'd31;
      default:                  len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before m (at most January through November).
  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] days;
    case (m)
      4'd0, 4'd1: days = 9'd0;
      4'd2:       days = 9'd31;
      4'd3:       days = 9'd59;
      4'd4:       days = 9'd90;
      4'd5:       days = 9'd120;
      4'd6:       days = 9'd151;
      4'd7:       days = 9'd181;
      4'd8:       days = 9'd212;
      4'd9:       days = 9'd243;
      4'd10:      days = 9'd273;
      4'd11:      days = 9'd304;
      default:    days = 9'd334;
    endcase
    if (leap && m >= 4'd3) begin
      days = days + 9'd1;
    end
    return days;
  endfunction

endpackage

/* hdl/calendar_clock.sv */
// Calendar clock: one-second ticks and date loads on a streaming interface.
// An accepted input beat goes to the input register, then the result register.
// Throughput: one beat per cycle unless out_tready stalls; each calendar update
// is one pass of compare/increment logic between input and result registers.
// Reset (rst_n low, synchronous): both pipeline stages empty, clock set to
// 00:00:00 on January 1st of year 2000, weekday/week/day-of-year 1, day total 0.
`include "assert_macros.svh"

module calendar_clock
  import cal_clk_pkg::*;
#(
  parameter int YEAR_BITS = 16   // year counter width, 12..32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,   // op: 0 tick, 1 load date
  // load_year[15:0], load_month[19:16], load_day[24:20], load_hour[29:25],
  // load_minute[35:30], zero pad [39:36]
  input  logic [39:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22],
  // year[41:26], day_of_year[50:42], weekday[53:51], week_of_year[59:54],
  // seconds_of_day[76:60], rollover[78:77], total_days[110:79], zero pad [111]
  output logic [111:0] out_tdata
);

  // ---------------------------------------------------------------------------
  // Stage 1: input register. A beat waits here until the result register can
  // take its update; the stage refills in the same cycle it drains.
  // ---------------------------------------------------------------------------
  logic     s1_valid_r;
  logic     s1_op_r;
  in_data_t s1_data_r;
  logic     out_valid_r;
  out_data_t out_data_r;
  logic     adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Calendar state. It only moves when a stage-1 beat goes to the output.
  // ---------------------------------------------------------------------------
  logic [5:0]           sec_r,     sec_nxt;
  logic [5:0]           min_r,     min_nxt;
  logic [4:0]           hour_r,    hour_nxt;
  logic [4:0]           day_r,     day_nxt;
  logic [3:0]           month_r,   month_nxt;
  logic [YEAR_BITS-1:0] year_r,    year_nxt;
  logic [8:0]           yday_r,    yday_nxt;
  logic [2:0]           wday_r,    wday_nxt;
  logic [5:0]           week_r,    week_nxt;
  logic [31:0]          elapsed_r, elapsed_nxt;
  logic [1:0]           roll_nxt;

  // Tick path: carries, evaluated against the current (pre-step) state.
  logic [5:0]  sec_inc, min_inc;
  logic [4:0]  hour_inc;
  logic        leap_cur;
  logic [4:0]  mlen;
  logic        yday_wrap, wday_wrap, month_end, year_end;
  logic [4:0]  day_adv;
  logic [3:0]  month_adv;
  logic [YEAR_BITS-1:0] year_adv;
  logic [2:0]  wday_adv;
  logic [5:0]  week_adv;
  logic [8:0]  yday_adv;

  assign sec_inc  = sec_r + 6'd1;
  assign min_inc  = min_r + 6'd1;
  assign hour_inc = hour_r + 5'd1;
  assign leap_cur = (year_r[1:0] == 2'b00);
  assign mlen     = month_len(month_r, leap_cur);

  // Day-of-year wrap uses the year before any new-year carry of this step.
  assign yday_wrap = (yday_r == DAYS_LEAP && leap_cur) ||
                     (yday_r == DAYS_YEAR && !leap_cur);
  assign wday_wrap = (wday_r == WEEKDAY_LAST);
  // Months 0 and 13..15 have no end: the day simply wraps at its width.
  assign month_end = (mlen != 5'd0) && (day_r == mlen);
  assign year_end  = month_end && (month_r == MONTH_DEC);

  assign day_adv   = month_end ? DAY_FIRST : day_r + 5'd1;
  assign month_adv = !month_end ? month_r : (year_end ? MONTH_JAN : month_r + 4'd1);
  assign year_adv  = year_end ? year_r + YEAR_BITS'(1) : year_r;
  assign wday_adv  = wday_wrap ? 3'd1 : wday_r + 3'd1;
  // New year forces week 1 even when the weekday also wrapped.
  assign week_adv  = year_end ? 6'd1 : (wday_wrap ? week_r + 6'd1 : week_r);
  assign yday_adv  = yday_wrap ? 9'd1 : yday_r + 9'd1;

  // Load path: day of year from a month table, then split by 7 with a
  // reciprocal multiply (73/512) and one correction step.
  logic        load_leap;
  logic [8:0]  load_doy;
  logic [15:0] doy_prod;
  logic [6:0]  q_est;
  logic [8:0]  r_est;
  logic [6:0]  doy_q;
  logic [2:0]  doy_r;
  logic [2:0]  load_wday;
  logic [31:0] load_year_ext;

  assign load_leap     = (s1_data_r.load_year[1:0] == 2'b00);
  assign load_doy      = days_before(s1_data_r.load_month, load_leap) +
                         9'(s1_data_r.load_day);
  assign doy_prod      = 16'(load_doy) * 16'd73;
  assign q_est         = doy_prod[15:9];
  assign r_est         = load_doy - 9'(q_est) * 9'd7;
  assign load_year_ext = 32'(s1_data_r.load_year);

  always_comb begin
    if (r_est >= 9'd7) begin
      doy_q = q_est + 7'd1;
      doy_r = 3'(r_est - 9'd7);
    end else begin
      doy_q = q_est;
      doy_r = r_est[2:0];
    end
    // (doy-1) mod 7 + 1: a zero remainder means the seventh day.
    if (load_doy == 9'd0) begin
      load_wday = 3'd0;
    end else if (doy_r == 3'd0) begin
      load_wday = WEEKDAY_LAST;
    end else begin
      load_wday = doy_r;
    end
  end

  // Next state.
  always_comb begin
    sec_nxt     = sec_r;
    min_nxt     = min_r;
    hour_nxt    = hour_r;
    day_nxt     = day_r;
    month_nxt   = month_r;
    year_nxt    = year_r;
    yday_nxt    = yday_r;
    wday_nxt    = wday_r;
    week_nxt    = week_r;
    elapsed_nxt = elapsed_r;
    roll_nxt    = ROLL_NONE;
    if (s1_op_r == OP_LOAD) begin
      sec_nxt     = 6'd0;
      min_nxt     = s1_data_r.load_minute;
      hour_nxt    = s1_data_r.load_hour;
      day_nxt     = s1_data_r.load_day;
      month_nxt   = s1_data_r.load_month;
      year_nxt    = load_year_ext[YEAR_BITS-1:0];
      yday_nxt    = load_doy;
      wday_nxt    = load_wday;
      week_nxt    = 6'(doy_q + 7'd1);
      elapsed_nxt = 32'd0;
    end else if (sec_inc != SEC_WRAP) begin
      sec_nxt = sec_inc;
    end else begin
      sec_nxt = 6'd0;
      if (min_inc != MIN_WRAP) begin
        min_nxt = min_inc;
      end else begin
        min_nxt = 6'd0;
        if (hour_inc != HOUR_WRAP) begin
          hour_nxt = hour_inc;
          roll_nxt = ROLL_HOUR;
        end else begin
          hour_nxt    = 5'd0;
          day_nxt     = day_adv;
          month_nxt   = month_adv;
          year_nxt    = year_adv;
          yday_nxt    = yday_adv;
          wday_nxt    = wday_adv;
          week_nxt    = week_adv;
          elapsed_nxt = elapsed_r + 32'd1;
          roll_nxt    = month_end ? ROLL_MONTH : ROLL_DAY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r     <= 6'd0;
      min_r     <= 6'd0;
      hour_r    <= 5'd0;
      day_r     <= DAY_FIRST;
      month_r   <= MONTH_JAN;
      year_r    <= RESET_YEAR[YEAR_BITS-1:0];
      yday_r    <= 9'd1;
      wday_r    <= 3'd1;
      week_r    <= 6'd1;
      elapsed_r <= 32'd0;
    end else if (adv) begin
      sec_r     <= sec_nxt;
      min_r     <= min_nxt;
      hour_r    <= hour_nxt;
      day_r     <= day_nxt;
      month_r   <= month_nxt;
      year_r    <= year_nxt;
      yday_r    <= yday_nxt;
      wday_r    <= wday_nxt;
      week_r    <= week_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: result register, holds the post-step view until taken.
  // ---------------------------------------------------------------------------
  logic [31:0] year_out_ext;
  out_data_t   out_data_nxt;

  assign year_out_ext = 32'(year_nxt);

  always_comb begin
    out_data_nxt                = '0;
    out_data_nxt.second         = sec_nxt;
    out_data_nxt.minute         = min_nxt;
    out_data_nxt.hour           = hour_nxt;
    out_data_nxt.day            = day_nxt;
    out_data_nxt.month          = month_nxt;
    out_data_nxt.year           = year_out_ext[15:0];
    out_data_nxt.day_of_year    = yday_nxt;
    out_data_nxt.weekday        = wday_nxt;
    out_data_nxt.week_of_year   = week_nxt;
    // Even out-of-range loads fit; the sum is kept in 17 bits.
    out_data_nxt.seconds_of_day = 17'(sec_nxt) + 17'(min_nxt) * 17'd60 +
                                  17'(hour_nxt) * 17'd3600;
    out_data_nxt.rollover       = roll_nxt;
    out_data_nxt.total_days     = elapsed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !s1_valid_r && !out_valid_r, "pipeline not empty after reset")
  `ASSERT_CLK(a_stall_full, clk, rst_n, !in_tready |-> s1_valid_r && out_valid_r, "input stalled with free stage")
  `ASSERT_CLK(a_state_hold, clk, rst_n, !adv |=> $stable(elapsed_r) && $stable(sec_r) && $stable(yday_r), "calendar moved without a beat")
  `ASSERT_CLK(a_load_clear, clk, rst_n, adv && s1_op_r == OP_LOAD |=> out_data_r.total_days == 32'd0 && out_data_r.rollover == ROLL_NONE && out_data_r.second == 6'd0, "load did not clear counters")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for calendar_clock: ticks, date loads and calendar rollovers.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cal_clk_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 1650;
  localparam int MAX_REPORTS  = 50;

  // Receiver stall patterns, one picked at random each time rx_phase wraps.
  typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic         in_tuser = OP_TICK;
  logic [39:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;

  // Predicted calendar state, updated at each accepted input beat.
  logic [5:0]  cal_sec   = '0;
  logic [5:0]  cal_min   = '0;
  logic [4:0]  cal_hour  = '0;
  logic [4:0]  cal_day   = DAY_FIRST;
  logic [3:0]  cal_month = MONTH_JAN;
  logic [15:0] cal_year  = RESET_YEAR[15:0];
  logic [8:0]  cal_yday  = 9'd1;
  logic [2:0]  cal_wday  = 3'd1;
  logic [5:0]  cal_week  = 6'd1;
  logic [31:0] cal_days  = '0;

  out_data_t   pending_readings[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          beats_sent  = 0;
  int          burst_left  = 0;
  rx_pattern_t rx_pattern  = RX_STEADY;
  logic [7:0]  rx_phase    = '0;

  calendar_clock u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver back-pressure: steady, light, heavy or periodic stalls.
  always @(posedge clk) begin
    rx_phase = rx_phase + 8'd1;
    if (rx_phase == 8'd0) begin
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
    end
    case (rx_pattern)
      RX_STEADY: begin
        out_tready <= 1'b1;
      end
      RX_LIGHT: begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      RX_HEAVY: begin
        out_tready <= ($urandom_range(0, 9) < 4);
      end
      default: begin
        out_tready <= (rx_phase[2:0] < 3'd5);
      end
    endcase
  end

  function automatic int unsigned month_days(input logic [3:0] m, input logic [15:0] y);
    case (m)
      4'd2:                                   return (y[1:0] == 2'b00) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11:                return 30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
      default:                                return 0;  // not a month: no month end
    endcase
  endfunction

  // Advance the predicted calendar by one beat and return the reading it shows.
  task automatic step_calendar(input logic op, input in_data_t d, output out_data_t r);
    logic [1:0]  roll;
    int unsigned doy;
    int unsigned len;
    logic        leap;
    logic [31:0] sod;
    roll = ROLL_NONE;
    if (op == OP_LOAD) begin
      // Day of year: months before the loaded one (January..November at most).
      doy = 0;
      for (int m = 1; m < d.load_month && m <= 11; m++) begin
        doy += month_days(4'(m), d.load_year);
      end
      doy += d.load_day;
      cal_year  = d.load_year;
      cal_month = d.load_month;
      cal_day   = d.load_day;
      cal_hour  = d.load_hour;
      cal_min   = d.load_minute;
      cal_sec   = '0;
      cal_yday  = doy[8:0];
      cal_week  = 6'(doy / 7 + 1);
      cal_wday  = (doy == 0) ? 3'd0 : 3'((doy - 1) % 7 + 1);
      cal_days  = '0;
    end else begin
      cal_sec = cal_sec + 6'd1;
      if (cal_sec == SEC_WRAP) begin
        cal_min = cal_min + 6'd1;
        if (cal_min == MIN_WRAP) begin
          cal_hour = cal_hour + 5'd1;
          roll = ROLL_HOUR;
          if (cal_hour == HOUR_WRAP) begin
            // New day; tests use the year as it was before any year change.
            len  = month_days(cal_month, cal_year);
            leap = (cal_year[1:0] == 2'b00);
            if ((cal_yday == DAYS_LEAP && leap) || (cal_yday == DAYS_YEAR && !leap)) begin
              cal_yday = '0;
            end
            if (cal_wday == WEEKDAY_LAST) begin
              cal_wday = '0;
              cal_week = cal_week + 6'd1;
            end
            roll = ROLL_DAY;
            if (len != 0 && cal_day == len) begin
              cal_day = '0;
              roll = ROLL_MONTH;
              if (cal_month == MONTH_DEC) begin
                cal_year  = cal_year + 16'd1;
                cal_month = MONTH_JAN;
                cal_week  = 6'd1;
              end else begin
                cal_month = cal_month + 4'd1;
              end
            end
            cal_day  = cal_day + 5'd1;
            cal_wday = cal_wday + 3'd1;
            cal_yday = cal_yday + 9'd1;
            cal_days = cal_days + 32'd1;
            cal_hour = '0;
          end
          cal_min = '0;
        end
        cal_sec = '0;
      end
    end
    sod = 32'(cal_sec) + 32'd60 * 32'(cal_min) + 32'd3600 * 32'(cal_hour);
    r = '0;
    r.second         = cal_sec;
    r.minute         = cal_min;
    r.hour           = cal_hour;
    r.day            = cal_day;
    r.month          = cal_month;
    r.year           = cal_year;
    r.day_of_year    = cal_yday;
    r.weekday        = cal_wday;
    r.week_of_year   = cal_week;
    r.seconds_of_day = sod[16:0];
    r.rollover       = roll;
    r.total_days     = cal_days;
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  // Scoreboard: predict on input handshakes, check on output handshakes.
  always @(posedge clk) begin
    out_data_t want;
    out_data_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        step_calendar(in_tuser, in_data_t'(in_tdata), want);
        pending_readings.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = out_data_t'(out_tdata);
        if (pending_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected output beat %h", out_tdata));
        end else begin
          want = pending_readings.pop_front();
          compare_field("second",         32'(got.second),         32'(want.second));
          compare_field("minute",         32'(got.minute),         32'(want.minute));
          compare_field("hour",           32'(got.hour),           32'(want.hour));
          compare_field("day",            32'(got.day),            32'(want.day));
          compare_field("month",          32'(got.month),          32'(want.month));
          compare_field("year",           32'(got.year),           32'(want.year));
          compare_field("day_of_year",    32'(got.day_of_year),    32'(want.day_of_year));
          compare_field("weekday",        32'(got.weekday),        32'(want.weekday));
          compare_field("week_of_year",   32'(got.week_of_year),   32'(want.week_of_year));
          compare_field("seconds_of_day", 32'(got.seconds_of_day), 32'(want.seconds_of_day));
          compare_field("rollover",       32'(got.rollover),       32'(want.rollover));
          compare_field("total_days",     got.total_days,          want.total_days);
        end
      end
    end
  end

  // Send one beat; bursts of random length separated by random gaps,
  // with occasional long gap-free bursts.
  task automatic send_beat(input logic op, input in_data_t d);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(40, 120);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Hold off the sender until every predicted reading has been checked.
  task automatic wait_for_readings();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  function automatic in_data_t pack_date(input logic [15:0] y, input logic [3:0] m,
                                         input logic [4:0] dd, input logic [4:0] h,
                                         input logic [5:0] mi);
    in_data_t d;
    d = '0;
    d.load_year   = y;
    d.load_month  = m;
    d.load_day    = dd;
    d.load_hour   = h;
    d.load_minute = mi;
    return d;
  endfunction

  // Any bit pattern the fields can hold, out-of-range values included.
  function automatic in_data_t random_fields();
    return pack_date(16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                     6'($urandom));
  endfunction

  function automatic logic random_op();
    return ($urandom_range(0, 1) == 1) ? OP_LOAD : OP_TICK;
  endfunction

  // Load a date near a boundary, then tick to within three ticks either side of it.
  task automatic run_to_boundary(input logic [15:0] y, input logic [3:0] m,
                                 input logic [4:0] dd, input logic [4:0] h,
                                 input logic [5:0] mi);
    int ticks;
    ticks = ((mi == 6'd58) ? 120 : 60) + $urandom_range(0, 6) - 3;
    send_beat(OP_LOAD, pack_date(y, m, dd, h, mi));
    repeat (ticks) send_beat(OP_TICK, random_fields());
  endtask

  // Ticks straight out of reset: Jan 1st 2000, 00:00:00.
  task automatic test_reset_state();
    repeat (3) send_beat(OP_TICK, random_fields());
  endtask

  // Field extremes, out-of-range months/days/hours/minutes, leap day, day zero.
  task automatic test_field_extremes();
    send_beat(OP_LOAD, pack_date(16'd0, 4'd1, 5'd1, 5'd0, 6'd0));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, pack_date(16'hFFFF, MONTH_DEC, 5'd31, 5'd23, 6'd59));
    send_beat(OP_TICK, '1);
    send_beat(OP_LOAD, '1);                                   // every bit set
    send_beat(OP_TICK, '0);
    send_beat(OP_TICK, '1);
    send_beat(OP_LOAD, '0);                                   // month 0, day 0
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, pack_date(16'd2024, 4'd2, 5'd29, 5'd12, 6'd30));
    send_beat(OP_LOAD, pack_date(16'd2023, 4'd13, 5'd5, 5'd1, 6'd2));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, pack_date(16'd2023, 4'd2, 5'd31, 5'd31, 6'd63));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, pack_date(16'd2100, 4'd3, 5'd1, 5'd0, 6'd0));
    send_beat(OP_LOAD, pack_date(16'd7, 4'd12, 5'd31, 5'd24, 6'd60));
    send_beat(OP_TICK, '1);
  endtask

  // Mostly well-formed boundary runs with random content, plus random noise.
  task automatic test_calendar_runs();
    int          target;
    int          runs;
    logic [15:0] y;
    logic [3:0]  m;
    logic [4:0]  dd;
    logic [4:0]  h;
    logic [5:0]  mi;
    target = beats_sent + RANDOM_BEATS;
    runs = 0;
    // New year in a leap year and at the 16-bit year wrap.
    y = 16'($urandom);
    y[1:0] = 2'b00;
    run_to_boundary(y, MONTH_DEC, 5'd31, 5'd23, 6'd59);
    run_to_boundary(16'hFFFF, MONTH_DEC, 5'd31, 5'd23, 6'd59);
    while (beats_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 7))
          0:       y = 16'hFFFF;
          1:       y = 16'h0000;
          default: y = 16'($urandom);
        endcase
        m = ($urandom_range(0, 2) == 0) ? MONTH_DEC : 4'($urandom_range(1, 12));
        case ($urandom_range(0, 4))
          0:       dd = 5'($urandom_range(1, 31));
          1:       dd = 5'($urandom_range(28, 31));
          default: dd = 5'(month_days(m, y));
        endcase
        h  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 23)) : 5'd23;
        mi = ($urandom_range(0, 4) == 0) ? 6'd58 : 6'd59;
        run_to_boundary(y, m, dd, h, mi);
      end else begin
        repeat ($urandom_range(1, 8)) send_beat(random_op(), random_fields());
      end
      runs++;
      if (runs % 8 == 0) begin
        wait_for_readings();
      end
    end
    wait_for_readings();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    wait_for_readings();
    test_field_extremes();
    wait_for_readings();
    test_calendar_runs();
    // Catch any stray beat left in the pipeline.
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
